[design/scb_pkg.sv]
// Shared types and constants for the spatial cell-list binning block.
// Holds the cell-memory entry layout, the controller state type, the
// command/status structs and the configuration register codes.
`default_nettype none

package scb_pkg;

    localparam int CELLS_Y     = 14;
    localparam int CELLS_Z     = 14;
    localparam int NODES       = 1024;

    localparam int CELL_AW     = 12;
    localparam int CELL_DEPTH  = 1 << CELL_AW;
    localparam int NODE_W      = 10;
    localparam int POP_W       = 11;
    localparam int POS_W       = 32;
    localparam int INV_W       = 32;
    localparam int DIFF_W      = POS_W + 1;
    localparam int NAT_W       = 4;
    localparam int NAT_PACK_W  = 3 * NAT_W;
    localparam int AIDX_W      = NAT_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int POP_SAT     = (NODES > 2047) ? 2047 : NODES;
    localparam int PLANE_STEP  = CELLS_Y + 2;
    localparam int ROW_STEP    = CELLS_Z + 2;

    localparam int IN_BITS     = NODE_W + 3 * POS_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = CELL_AW + NODE_W + POP_W;
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [POS_W-1:0]      ORIGIN_RESET   = '0;
    localparam logic [INV_W-1:0]      INV_RESET      = INV_W'(65536);
    localparam logic [NAT_PACK_W-1:0] NAT_LOW_RESET  = '0;
    localparam logic [NAT_PACK_W-1:0] NAT_HIGH_RESET = NAT_PACK_W'(3549);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_INV_CELL_X  = 3'd3,
        CFG_INV_CELL_Y  = 3'd4,
        CFG_INV_CELL_Z  = 3'd5,
        CFG_NATIVE_LOW  = 3'd6,
        CFG_NATIVE_HIGH = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIFF,
        ST_MAG,
        ST_MUL,
        ST_CLAMP,
        ST_LIN,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] head;
        logic [POP_W-1:0]  pop;
    } cell_entry_t;

    typedef struct packed {
        logic in_load;
        logic clr_wr;
        logic cell_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic clr_last;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

[design/spatial_cell_list_binning.sv]
// Spatial cell-list binning, top level: streaming input and result ports
// plus a register write port. Instantiates scb_ctrl and scb_datapath.
// An insert transaction is walked by the controller through difference,
// magnitude, multiply, clamp, index, memory read and read-modify-write of the
// single cell memory before the next one is accepted; the last step waits
// while a previous result is still held on the output. A clear transaction
// produces no result and sweeps the 4096-entry cell memory one entry per
// cycle, and the input stays stalled until the sweep ends. After reset the
// same sweep runs before the first transaction is accepted. Register writes
// are taken in any cycle, but the datapath reads the registers on every step
// of an insert, so they belong between transactions.
`default_nettype none

module spatial_cell_list_binning
    import scb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // node_id, pos_x, pos_y, pos_z, zero fill
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // action
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // cell_index, prev_head, cell_count, zero fill
    output logic [M_TDATA_W-1:0]       m_tdata,
    // prev_head_valid
    output logic                       m_tuser
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    scb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

[design/scb_cell_mem.sv]
// Cell memory: one entry per cell holding the list head and population.
// One write port and one read port with registered read data; uses scb_pkg.
`default_nettype none

module scb_cell_mem
    import scb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [CELL_AW-1:0] wr_addr,
    input  wire cell_entry_t        wr_data,
    input  wire logic [CELL_AW-1:0] rd_addr,
    output cell_entry_t             rd_data
);

    cell_entry_t mem [CELL_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[design/scb_datapath.sv]
// Datapath: configuration registers, per-axis scaling and clamping, the
// linear cell index, the cell memory update and the result register.
// Uses scb_pkg and instantiates scb_cell_mem.
`default_nettype none

module scb_datapath
    import scb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tuser,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat
);

    logic [POS_W-1:0]      origin_reg [3];
    logic [INV_W-1:0]      inv_reg [3];
    logic [NAT_PACK_W-1:0] nat_low_reg;
    logic [NAT_PACK_W-1:0] nat_high_reg;

    logic                  action_reg;
    logic [NODE_W-1:0]     node_reg;
    logic [POS_W-1:0]      pos_reg [3];
    logic [DIFF_W-1:0]     diff_reg [3];
    logic [POS_W-1:0]      mag_reg [3];
    logic                  neg_reg [3];
    logic [INV_W-1:0]      ip_reg [3];
    logic [AIDX_W-1:0]     axis_reg [3];
    logic [CELL_AW-1:0]    idx_reg;
    logic [CELL_AW-1:0]    clr_cnt_reg;

    logic                  m_valid_reg;
    logic [CELL_AW-1:0]    m_idx_reg;
    logic [NODE_W-1:0]     m_head_reg;
    logic                  m_head_valid_reg;
    logic [POP_W-1:0]      m_pop_reg;

    logic [DIFF_W-1:0]     diff_next [3];
    logic [POS_W-1:0]      mag_next [3];
    logic [INV_W-1:0]      ip_next [3];
    logic [AIDX_W-1:0]     axis_next [3];
    logic [CELL_AW-1:0]    idx_next;

    cell_entry_t           rd_entry;
    cell_entry_t           wr_entry;
    logic                  mem_wr_en;
    logic [CELL_AW-1:0]    mem_wr_addr;
    logic                  was_used;
    logic [POP_W-1:0]      pop_new;
    logic [NODE_W-1:0]     head_old;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                origin_reg[a] <= ORIGIN_RESET;
                inv_reg[a]    <= INV_RESET;
            end
            nat_low_reg  <= NAT_LOW_RESET;
            nat_high_reg <= NAT_HIGH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ORIGIN_X:    origin_reg[0] <= cfg_wdata[POS_W-1:0];
                CFG_ORIGIN_Y:    origin_reg[1] <= cfg_wdata[POS_W-1:0];
                CFG_ORIGIN_Z:    origin_reg[2] <= cfg_wdata[POS_W-1:0];
                CFG_INV_CELL_X:  inv_reg[0]    <= cfg_wdata[INV_W-1:0];
                CFG_INV_CELL_Y:  inv_reg[1]    <= cfg_wdata[INV_W-1:0];
                CFG_INV_CELL_Z:  inv_reg[2]    <= cfg_wdata[INV_W-1:0];
                CFG_NATIVE_LOW:  nat_low_reg   <= cfg_wdata[NAT_PACK_W-1:0];
                CFG_NATIVE_HIGH: nat_high_reg  <= cfg_wdata[NAT_PACK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            action_reg <= s_tuser;
            node_reg   <= s_tdata[NODE_W-1:0];
            for (int a = 0; a < 3; a++) begin
                pos_reg[a] <= s_tdata[NODE_W + a*POS_W +: POS_W];
            end
        end
    end

    always_comb begin
        logic [2*POS_W-1:0] prod;
        logic [INV_W-1:0]   lo;
        logic [INV_W-1:0]   hi;
        logic [INV_W-1:0]   raised;
        logic [INV_W-1:0]   lowered;
        for (int a = 0; a < 3; a++) begin
            diff_next[a] = {pos_reg[a][POS_W-1], pos_reg[a]}
                         - {origin_reg[a][POS_W-1], origin_reg[a]};
            mag_next[a]  = diff_reg[a][DIFF_W-1] ? POS_W'(~diff_reg[a] + 1'b1)
                                                 : diff_reg[a][POS_W-1:0];
            prod         = {{POS_W{1'b0}}, mag_reg[a]} * {{POS_W{1'b0}}, inv_reg[a]};
            ip_next[a]   = prod[2*POS_W-1:POS_W];
            lo           = INV_W'(nat_low_reg[a*NAT_W +: NAT_W]);
            hi           = INV_W'(nat_high_reg[a*NAT_W +: NAT_W]);
            if ((neg_reg[a] && (ip_reg[a] != '0)) || (ip_reg[a] < lo)) begin
                raised = lo;
            end else begin
                raised = ip_reg[a];
            end
            lowered      = (raised > hi) ? hi : raised;
            axis_next[a] = AIDX_W'(lowered[NAT_W-1:0]) + AIDX_W'(1);
        end
    end

    assign idx_next = (CELL_AW'(axis_reg[0]) * CELL_AW'(PLANE_STEP)
                      + CELL_AW'(axis_reg[1])) * CELL_AW'(ROW_STEP)
                      + CELL_AW'(axis_reg[2]);

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            diff_reg[a] <= diff_next[a];
            neg_reg[a]  <= diff_reg[a][DIFF_W-1];
            mag_reg[a]  <= mag_next[a];
            ip_reg[a]   <= ip_next[a];
            axis_reg[a] <= axis_next[a];
        end
        idx_reg <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.in_load) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign was_used = (rd_entry.pop != '0);
    assign head_old = was_used ? rd_entry.head : '0;
    assign pop_new  = (rd_entry.pop < POP_W'(POP_SAT)) ? rd_entry.pop + 1'b1
                                                       : rd_entry.pop;

    assign mem_wr_en   = cmd.clr_wr | cmd.cell_wr;
    assign mem_wr_addr = cmd.clr_wr ? clr_cnt_reg : idx_reg;

    always_comb begin
        if (cmd.clr_wr) begin
            wr_entry = '0;
        end else begin
            wr_entry.head = node_reg;
            wr_entry.pop  = pop_new;
        end
    end

    scb_cell_mem u_cell_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (wr_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.cell_wr) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cell_wr) begin
            m_idx_reg        <= idx_reg;
            m_head_reg       <= head_old;
            m_head_valid_reg <= was_used;
            m_pop_reg        <= pop_new;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_head_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_BITS){1'b0}}, m_pop_reg, m_head_reg, m_idx_reg};

    assign stat.is_insert = action_reg;
    assign stat.clr_last  = &clr_cnt_reg;
    assign stat.out_busy  = m_valid_reg & ~m_tready;

endmodule

`default_nettype wire

[design/scb_ctrl.sv]
// Controller state machine that sequences the clearing sweep and the
// steps of one insert through the datapath. Uses scb_pkg.
`default_nettype none

module scb_ctrl
    import scb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                state_next = stat.is_insert ? ST_MAG : ST_CLEAR;
            end
            ST_MAG:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_LIN;
            ST_LIN:   state_next = ST_READ;
            ST_READ:  state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == ST_IDLE);
        cmd.in_load = (state_reg == ST_IDLE) && s_tvalid;
        cmd.clr_wr  = (state_reg == ST_CLEAR);
        cmd.cell_wr = (state_reg == ST_UPDATE) && !stat.out_busy;
    end

endmodule

`default_nettype wire

[dv/spatial_cell_list_binning_test.sv]
// Self-checking testbench for spatial_cell_list_binning: drives insert and clear
// transactions with random idling on both streams and checks every result.
// Depends on scb_pkg and the block's RTL only.

module spatial_cell_list_binning_test;
    timeunit 1ns;
    timeprecision 1ps;
    import scb_pkg::*;

    localparam logic ACT_CLEAR   = 1'b0;
    localparam logic ACT_INSERT  = 1'b1;
    localparam int   IDLE_LIMIT  = 20000;
    localparam int   CLEAR_DRAIN = 4200;

    typedef struct packed {
        logic [CELL_AW-1:0] bin_cell;
        logic [NODE_W-1:0]  prev_head;
        logic               head_valid;
        logic [POP_W-1:0]   cell_count;
    } bin_result_t;

    class cell_list_tracker;
        logic signed [POS_W-1:0] origin [3];
        logic [INV_W-1:0]        inv_cell [3];
        logic [NAT_PACK_W-1:0]   nat_low;
        logic [NAT_PACK_W-1:0]   nat_high;
        bit                      used [CELL_DEPTH];
        logic [NODE_W-1:0]       head [CELL_DEPTH];
        logic [POP_W-1:0]        population [CELL_DEPTH];
        bin_result_t             expected_bins [$];
        int                      errors;

        function new();
            foreach (origin[a]) begin
                origin[a]   = ORIGIN_RESET;
                inv_cell[a] = INV_RESET;
            end
            nat_low  = NAT_LOW_RESET;
            nat_high = NAT_HIGH_RESET;
            foreach (head[c]) head[c] = '0;
            empty_cells();
            errors = 0;
        endfunction

        function void empty_cells();
            foreach (used[c]) begin
                used[c]       = 1'b0;
                population[c] = '0;
            end
        endfunction

        function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
            case (r)
                CFG_ORIGIN_X:    origin[0]   = v;
                CFG_ORIGIN_Y:    origin[1]   = v;
                CFG_ORIGIN_Z:    origin[2]   = v;
                CFG_INV_CELL_X:  inv_cell[0] = v;
                CFG_INV_CELL_Y:  inv_cell[1] = v;
                CFG_INV_CELL_Z:  inv_cell[2] = v;
                CFG_NATIVE_LOW:  nat_low     = v[NAT_PACK_W-1:0];
                CFG_NATIVE_HIGH: nat_high    = v[NAT_PACK_W-1:0];
                default: ;
            endcase
        endfunction

        // Axis index including the border layer; truncation is toward zero.
        function int axis_bin(logic signed [POS_W-1:0] p, int a);
            longint          d;
            longint unsigned mag;
            longint unsigned ip;
            longint          c;
            int              lo;
            int              hi;
            lo  = nat_low[a*NAT_W +: NAT_W];
            hi  = nat_high[a*NAT_W +: NAT_W];
            d   = longint'(p) - longint'(origin[a]);
            mag = (d < 0) ? -d : d;
            ip  = (mag * inv_cell[a]) >> 32;
            c   = (d < 0) ? -longint'(ip) : longint'(ip);
            if (c < lo) c = lo;
            if (c > hi) c = hi;
            return int'(c) + 1;
        endfunction

        function void note_item(logic action, logic [NODE_W-1:0] node,
                                logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                logic [POS_W-1:0] pz);
            int                 i;
            int                 j;
            int                 k;
            logic [CELL_AW-1:0] idx;
            bin_result_t        r;
            if (action == ACT_CLEAR) begin
                empty_cells();
                return;
            end
            i   = axis_bin(px, 0);
            j   = axis_bin(py, 1);
            k   = axis_bin(pz, 2);
            idx = CELL_AW'((i * PLANE_STEP + j) * ROW_STEP + k);
            r.bin_cell   = idx;
            r.head_valid = used[idx];
            r.prev_head  = used[idx] ? head[idx] : '0;
            r.cell_count = used[idx] ? population[idx] : '0;
            if (r.cell_count < POP_SAT) r.cell_count++;
            used[idx]       = 1'b1;
            head[idx]       = node;
            population[idx] = r.cell_count;
            expected_bins.push_back(r);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_bin(logic [CELL_AW-1:0] bin_cell, logic [NODE_W-1:0] prev_head,
                                logic head_valid, logic [POP_W-1:0] cell_count);
            bin_result_t want;
            if (expected_bins.size() == 0) begin
                $display("%0t: result with none expected: cell %0h head %0h valid %0b count %0h",
                         $time, bin_cell, prev_head, head_valid, cell_count);
                errors++;
                return;
            end
            want = expected_bins.pop_front();
            if (bin_cell !== want.bin_cell) report("cell_index", want.bin_cell, bin_cell);
            if (prev_head !== want.prev_head) report("prev_head", want.prev_head, prev_head);
            if (head_valid !== want.head_valid)
                report("prev_head_valid", want.head_valid, head_valid);
            if (cell_count !== want.cell_count)
                report("cell_count", want.cell_count, cell_count);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    cell_list_tracker      tracker = new();
    int unsigned           span [3];
    logic [POS_W-1:0]      recent_pos [8][3];
    bit                    calm = 1'b0;
    int                    idle_cycles = 0;

    spatial_cell_list_binning dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic int unsigned axis_span(logic [INV_W-1:0] inv);
        longint unsigned s;
        if (inv < 32'h0000_2000) return 0;
        s = (64'd17 << 32) / inv;
        return (s > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(s);
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(int a);
        int unsigned s;
        s = span[a];
        if (s == 0 || $urandom_range(0, 9) == 0) return $urandom;
        return tracker.origin[a] + $urandom_range(0, s) - s / 8;
    endfunction

    initial begin
        foreach (recent_pos[n, a]) recent_pos[n][a] = '0;
        forever begin
            repeat ($urandom_range(200, 800)) @(posedge aclk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0) stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_bin(m_tdata[CELL_AW-1:0], m_tdata[CELL_AW +: NODE_W], m_tuser,
                              m_tdata[CELL_AW+NODE_W +: POP_W]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("spatial_cell_list_binning_test NOT OK");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        tracker.set_reg(r, v);
    endtask

    task automatic load_geometry(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                 logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                                 logic [11:0] lo, logic [11:0] hi);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_INV_CELL_X, ix);
        write_reg(CFG_INV_CELL_Y, iy);
        write_reg(CFG_INV_CELL_Z, iz);
        write_reg(CFG_NATIVE_LOW, CFG_DATA_W'(lo));
        write_reg(CFG_NATIVE_HIGH, CFG_DATA_W'(hi));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        foreach (span[a]) span[a] = axis_span(tracker.inv_cell[a]);
    endtask

    task automatic push_item(logic action, logic [NODE_W-1:0] node,
                             logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [POS_W-1:0] pz);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= S_TDATA_W'({pz, py, px, node});
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(action, node, px, py, pz);
    endtask

    // Positions are often reused so that inserts pile up on the same cells.
    task automatic run_random(int n, int clear_odds);
        int               slot;
        logic             action;
        logic [POS_W-1:0] pos [3];
        repeat (n) begin
            slot = $urandom_range(0, 7);
            if ($urandom_range(0, 2) == 0) begin
                pos = recent_pos[slot];
            end else begin
                foreach (pos[a]) pos[a] = pick_pos(a);
                recent_pos[slot] = pos;
            end
            action = (clear_odds > 0 && $urandom_range(1, clear_odds) == 1) ?
                     ACT_CLEAR : ACT_INSERT;
            push_item(action, NODE_W'($urandom_range(0, NODES - 1)), pos[0], pos[1], pos[2]);
        end
    endtask

    // A clear produces no result, so its sweep is waited out after the last result.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.expected_bins.size() != 0) @(posedge aclk);
        repeat (CLEAR_DRAIN) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_item(ACT_INSERT, 10'h000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_item(ACT_INSERT, 10'h3FF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_item(ACT_INSERT, 10'h005, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(ACT_INSERT, 10'h006, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_item(ACT_INSERT, 10'h2AA, 32'hFFFF_8000, 32'h0001_8000, 32'h000D_FFFF);
        push_item(ACT_INSERT, 10'h155, 32'h000E_0000, 32'h0002_FFFF, 32'hFFFF_FFFF);
        push_item(ACT_CLEAR, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(ACT_INSERT, 10'h007, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_item(ACT_INSERT, 10'h3FF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_item(ACT_INSERT, 10'h100, 32'h000D_0000, 32'h000D_0000, 32'h000D_0000);
        push_item(ACT_CLEAR, 10'h000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_item(ACT_CLEAR, 10'h000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_item(ACT_INSERT, 10'h2AA, 32'h000D_0000, 32'h000D_0000, 32'h000D_0000);
        push_item(ACT_INSERT, 10'h155, 32'h000D_8000, 32'h000D_4000, 32'h000D_C000);
        settle();

        load_geometry(32'hFFF8_0000, 32'h0003_0000, 32'h0000_0000,
                      32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 12'h000, 12'hDDD);
        run_random(300, 64);
        settle();

        load_geometry(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                      32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 12'hFFF, 12'hFFF);
        run_random(100, 32);
        settle();

        // Low bound above high bound on the y and z axes.
        load_geometry($urandom, $urandom, $urandom,
                      32'h0000_8000, 32'h0001_8000, 32'h0000_4000, 12'h9A5, 12'h326);
        run_random(150, 48);
        settle();

        // A single-cell range funnels every insert into one list until it saturates.
        load_geometry($urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, 12'h000, 12'h000);
        run_random(1030, 0);
        settle();

        load_geometry($urandom, $urandom, $urandom,
                      $urandom_range(32'h1000, 32'h40000), $urandom_range(32'h1000, 32'h40000),
                      $urandom_range(32'h1000, 32'h40000),
                      12'($urandom), 12'($urandom));
        run_random(300, 64);
        settle();

        if (tracker.errors == 0 && tracker.expected_bins.size() == 0) begin
            $display("spatial_cell_list_binning_test OK");
        end else begin
            $display("spatial_cell_list_binning_test NOT OK");
        end
        $finish;
    end

endmodule
